// ===== src/rqd_pkg.sv =====
// shared types, constants and codes for the red drop decision block
`default_nettype none
package rqd_pkg;

   // fixed point formats
   localparam int FRAC_BITS     = 16;
   localparam int QLEN_W        = 10;
   localparam int TIME_W        = 32;
   localparam int DRAW_W        = 7;
   localparam int AVG_W         = QLEN_W + FRAC_BITS;
   localparam int AVG8_W        = 18;
   localparam int THR_W         = 18;
   localparam int THR_SHIFT     = FRAC_BITS - 8;
   localparam int Q16_W         = 16;
   localparam int Q16P_W        = Q16_W + 1;
   localparam int COUNT_W       = 17;
   localparam int MAX_QUEUE_LEN = 1023;

   // shared multiply-add unit
   localparam int MAC_A_W  = AVG_W;
   localparam int MAC_B_W  = Q16P_W;
   localparam int MAC_M_W  = MAC_A_W + MAC_B_W;
   localparam int PROD_W   = MAC_M_W + 1;

   // iterative divider: quotient bits per division
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [Q16P_W-1:0]  ONE_Q16     = Q16P_W'(65536);
   localparam logic [Q16_W-1:0]   ROUND_HALF  = 16'h8000;
   localparam logic [DRAW_W-1:0]  DRAW_MAX    = DRAW_W'(99);
   localparam logic [MAC_B_W-1:0] PROB_SCALE  = MAC_B_W'(100);
   localparam logic [COUNT_W-1:0] COUNT_RESET = '1;
   localparam logic [COUNT_W-1:0] COUNT_SAT   = COUNT_W'(65535);
   localparam logic [AVG_W-1:0]   AVG_MAX     = AVG_W'(MAX_QUEUE_LEN) << FRAC_BITS;

   // drop cause codes
   localparam logic [1:0] CAUSE_NONE   = 2'd0;
   localparam logic [1:0] CAUSE_ABOVE  = 2'd1;
   localparam logic [1:0] CAUSE_RANDOM = 2'd2;
   localparam logic [1:0] CAUSE_LIMIT  = 2'd3;

   // csr register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 18;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_THR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_THR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PROB = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CNT_LIM  = 3'd5;

   typedef struct packed {
      logic [MAC_A_W-1:0] a;
      logic [MAC_B_W-1:0] b;
      logic [PROD_W-1:0]  c;
   } mac_req_type;

   typedef struct packed {
      logic                 start;
      logic [AVG_W-1:0]     high;
      logic [DIV_STEPS-1:0] low;
      logic [AVG_W-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_STEPS-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== src/rqd_mac.sv =====
// shared multiply-add unit with registered product
`default_nettype none
module rqd_mac (
   input  wire logic                  clock,
   input  wire rqd_pkg::mac_req_type  mac_req,
   output logic [rqd_pkg::PROD_W-1:0] prod
);
   import rqd_pkg::*;

   logic [MAC_M_W-1:0] mul;
   logic [PROD_W-1:0]  prod_in;
   logic [PROD_W-1:0]  prod_ff;

   assign mul     = mac_req.a * mac_req.b;
   assign prod_in = {1'b0, mul} + mac_req.c;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

// ===== src/rqd_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module rqd_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rqd_pkg::div_req_type div_req,
   output rqd_pkg::div_rsp_type      div_rsp
);
   import rqd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [AVG_W-1:0]     rem_ff, rem_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [AVG_W-1:0]     div_ff, div_in;
   logic [AVG_W:0]       rem_sh;
   logic [AVG_W:0]       rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, quo_ff[DIV_STEPS-1]};
   assign rem_sub = rem_sh - {1'b0, div_ff};
   assign ge      = rem_sh >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = div_req.high;
         quo_in  = div_req.low;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[AVG_W-1:0] : rem_sh[AVG_W-1:0];
         quo_in = {quo_ff[DIV_STEPS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/red_queue_drop_decision_top.sv =====
// random early detection drop decision: sequencer, state and csr block
`default_nettype none
// One packet arrival beat in, one decision beat out (accept, drop cause, Q10.8 average).
// The block works on one arrival at a time: req_ready is high only while the sequencer
// is idle, and a finished decision waits in the rsp register so a new arrival can be
// taken while it is pending. All arithmetic runs through one registered 26x17
// multiply-add unit plus a restoring divider of 16 quotient bits. A non-empty queue outside
// the random band passes the blend states w*q and (1-w)*avg + w*q, the average update,
// the threshold compare and the hand-off; an empty queue swaps the two blend states for
// the idle decay (1-w)^m by square-and-multiply, a square per clear bit and a multiply
// plus a square per set bit of the elapsed ticks up to the top set bit, then the decay
// multiply; the random band adds up to two divisions and three multiplies.
// Csr writes take effect at once and are meant only while idle.
module red_queue_drop_decision_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // arrival beats
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [rqd_pkg::QLEN_W-1:0]         req_queue_len,
   input  wire logic [rqd_pkg::TIME_W-1:0]         req_now_time,
   input  wire logic [rqd_pkg::DRAW_W-1:0]         req_random_draw,
   // decision beats
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_accept,
   output logic [1:0]                              rsp_drop_cause,
   output logic [rqd_pkg::AVG8_W-1:0]              rsp_avg_len_q8,
   // csr write port
   input  wire logic                               csr_we,
   input  wire logic [rqd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rqd_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import rqd_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_BL1  = 4'd1;   // w * q
   localparam logic [3:0] S_BL2  = 4'd2;   // (1-w) * avg + w * q
   localparam logic [3:0] S_PBIT = 4'd3;   // power loop, one elapsed-time bit
   localparam logic [3:0] S_PSQ  = 4'd4;   // power loop, square after a multiply
   localparam logic [3:0] S_AVG  = 4'd5;   // take new average
   localparam logic [3:0] S_CMP  = 4'd6;   // threshold compare
   localparam logic [3:0] S_PB1  = 4'd7;   // start pb division
   localparam logic [3:0] S_PB2  = 4'd8;   // wait pb division
   localparam logic [3:0] S_CP   = 4'd9;   // count * pb
   localparam logic [3:0] S_PA   = 4'd10;  // start pa division or saturate
   localparam logic [3:0] S_PA2  = 4'd11;  // wait pa division
   localparam logic [3:0] S_PR   = 4'd12;  // pa * 100
   localparam logic [3:0] S_DEC  = 4'd13;  // random drop compare
   localparam logic [3:0] S_DONE = 4'd14;  // hand result to rsp register

   // csr registers
   logic                  en_ff, en_in;
   logic [Q16_W-1:0]      weight_ff, weight_in;
   logic [THR_W-1:0]      min_thr_ff, min_thr_in;
   logic [THR_W-1:0]      max_thr_ff, max_thr_in;
   logic [Q16_W-1:0]      max_prob_ff, max_prob_in;
   logic [Q16_W-1:0]      cnt_lim_ff, cnt_lim_in;

   // persistent state
   logic [AVG_W-1:0]      avg_ff, avg_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [TIME_W-1:0]     idle_start_ff, idle_start_in;

   // per-arrival working registers
   logic [3:0]            state_ff, state_in;
   logic [QLEN_W-1:0]     q_ff, q_in;
   logic [DRAW_W-1:0]     draw_ff, draw_in;
   logic [TIME_W-1:0]     m_ff, m_in;
   logic [Q16P_W-1:0]     res_ff, res_in;
   logic [Q16P_W-1:0]     base_ff, base_in;
   logic                  pend_ff, pend_in;
   logic [Q16_W-1:0]      pb_ff, pb_in;
   logic [Q16P_W-1:0]     pa_ff, pa_in;
   logic                  acc_ff, acc_in;
   logic [1:0]            cause_ff, cause_in;

   // rsp register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic [1:0]            rsp_cause_ff, rsp_cause_in;
   logic [AVG8_W-1:0]     rsp_avg_ff, rsp_avg_in;

   // shared units
   mac_req_type           mac_req;
   logic [PROD_W-1:0]     prod;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   // derived values
   logic [Q16P_W-1:0]     factor;
   logic [AVG_W-1:0]      min_f;
   logic [AVG_W-1:0]      max_f;
   logic [Q16P_W-1:0]     base_cur;
   logic [Q16_W-1:0]      count_inc;
   logic                  cp_big;
   logic [Q16P_W-1:0]     d2;
   logic [PROD_W-1:0]     draw_scaled;
   logic                  load_rsp;

   assign factor      = ONE_Q16 - {1'b0, weight_ff};
   assign min_f       = {min_thr_ff, {THR_SHIFT{1'b0}}};
   assign max_f       = {max_thr_ff, {THR_SHIFT{1'b0}}};
   // a square issued last cycle lands in the product register
   assign base_cur    = pend_ff ? prod[2*Q16_W:Q16_W] : base_ff;
   // -1 steps to 0, 65535 holds
   assign count_inc   = count_ff[COUNT_W-1] ? '0 :
                        (count_ff == COUNT_SAT) ? count_ff[Q16_W-1:0] :
                        count_ff[Q16_W-1:0] + 1'b1;
   assign cp_big      = |prod[PROD_W-1:Q16_W];
   assign d2          = ONE_Q16 - prod[Q16_W:0];
   assign draw_scaled = {{(PROD_W-DRAW_W-FRAC_BITS){1'b0}}, draw_ff, {FRAC_BITS{1'b0}}};
   assign load_rsp    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   rqd_mac u_mac (
      .clock   (clock),
      .mac_req (mac_req),
      .prod    (prod)
   );

   rqd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // csr decode
   always_comb begin
      en_in       = en_ff;
      weight_in   = weight_ff;
      min_thr_in  = min_thr_ff;
      max_thr_in  = max_thr_ff;
      max_prob_in = max_prob_ff;
      cnt_lim_in  = cnt_lim_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ENABLE:   en_in       = csr_wdata[0];
            REG_WEIGHT:   weight_in   = csr_wdata[Q16_W-1:0];
            REG_MIN_THR:  min_thr_in  = csr_wdata[THR_W-1:0];
            REG_MAX_THR:  max_thr_in  = csr_wdata[THR_W-1:0];
            REG_MAX_PROB: max_prob_in = csr_wdata[Q16_W-1:0];
            REG_CNT_LIM:  cnt_lim_in  = csr_wdata[Q16_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      avg_in        = avg_ff;
      count_in      = count_ff;
      idle_start_in = idle_start_ff;
      q_in          = q_ff;
      draw_in       = draw_ff;
      m_in          = m_ff;
      res_in        = res_ff;
      base_in       = base_ff;
      pend_in       = 1'b0;
      pb_in         = pb_ff;
      pa_in         = pa_ff;
      acc_in        = acc_ff;
      cause_in      = cause_ff;
      mac_req       = '0;
      div_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               q_in          = req_queue_len;
               draw_in       = (req_random_draw > DRAW_MAX) ? DRAW_MAX : req_random_draw;
               // idle time runs from the previous arrival
               m_in          = req_now_time - idle_start_ff;
               idle_start_in = req_now_time;
               res_in        = ONE_Q16;
               base_in       = factor;
               state_in      = (req_queue_len == '0) ? S_PBIT : S_BL1;
            end
         end
         S_BL1: begin
            mac_req.a = MAC_A_W'(q_ff);
            mac_req.b = {1'b0, weight_ff};
            state_in  = S_BL2;
         end
         S_BL2: begin
            // w*q shifted up to the average format, plus rounding half
            mac_req.a = avg_ff;
            mac_req.b = factor;
            mac_req.c = {{(PROD_W-AVG_W-Q16_W){1'b0}}, prod[AVG_W-1:0], ROUND_HALF};
            state_in  = S_AVG;
         end
         S_PBIT: begin
            if (m_ff == '0) begin
               // decay the average by the finished power
               mac_req.a = avg_ff;
               mac_req.b = res_ff;
               mac_req.c = PROD_W'(ROUND_HALF);
               state_in  = S_AVG;
            end else if (m_ff[0]) begin
               mac_req.a = MAC_A_W'(res_ff);
               mac_req.b = base_cur;
               mac_req.c = PROD_W'(ROUND_HALF);
               base_in   = base_cur;
               state_in  = S_PSQ;
            end else begin
               mac_req.a = MAC_A_W'(base_cur);
               mac_req.b = base_cur;
               mac_req.c = PROD_W'(ROUND_HALF);
               base_in   = base_cur;
               pend_in   = 1'b1;
               m_in      = m_ff >> 1;
            end
         end
         S_PSQ: begin
            res_in    = prod[2*Q16_W:Q16_W];
            mac_req.a = MAC_A_W'(base_ff);
            mac_req.b = base_ff;
            mac_req.c = PROD_W'(ROUND_HALF);
            pend_in   = 1'b1;
            m_in      = m_ff >> 1;
            state_in  = S_PBIT;
         end
         S_AVG: begin
            avg_in   = prod[AVG_W+FRAC_BITS-1:FRAC_BITS];
            state_in = S_CMP;
         end
         S_CMP: begin
            acc_in   = 1'b1;
            cause_in = CAUSE_NONE;
            state_in = S_DONE;
            if (!en_ff) begin
               // red off: accept, count untouched
            end else if (avg_ff < min_f) begin
               count_in = COUNT_RESET;
            end else if (avg_ff > max_f) begin
               acc_in   = 1'b0;
               cause_in = CAUSE_ABOVE;
               count_in = '0;
            end else if (count_inc >= cnt_lim_ff) begin
               acc_in   = 1'b0;
               cause_in = CAUSE_LIMIT;
               count_in = '0;
            end else begin
               count_in = {1'b0, count_inc};
               if (max_f > min_f) begin
                  mac_req.a = avg_ff - min_f;
                  mac_req.b = {1'b0, max_prob_ff};
                  state_in  = S_PB1;
               end else begin
                  // empty range: pb is maxp
                  pb_in    = max_prob_ff;
                  state_in = S_CP;
               end
            end
         end
         S_PB1: begin
            div_req.start   = 1'b1;
            div_req.high    = prod[AVG_W+DIV_STEPS-1:DIV_STEPS];
            div_req.low     = prod[DIV_STEPS-1:0];
            div_req.divisor = max_f - min_f;
            state_in        = S_PB2;
         end
         S_PB2: begin
            if (div_rsp.done) begin
               pb_in    = div_rsp.quotient;
               state_in = S_CP;
            end
         end
         S_CP: begin
            mac_req.a = MAC_A_W'(count_ff[Q16_W-1:0]);
            mac_req.b = {1'b0, pb_ff};
            state_in  = S_PA;
         end
         S_PA: begin
            // pa saturates at 1.0 once cp reaches 1.0 or pb/(1-cp) reaches 1.0
            if (cp_big || ({1'b0, pb_ff} >= d2)) begin
               pa_in    = ONE_Q16;
               state_in = S_PR;
            end else begin
               div_req.start   = 1'b1;
               div_req.high    = AVG_W'(pb_ff);
               div_req.low     = '0;
               div_req.divisor = AVG_W'(d2);
               state_in        = S_PA2;
            end
         end
         S_PA2: begin
            if (div_rsp.done) begin
               pa_in    = {1'b0, div_rsp.quotient};
               state_in = S_PR;
            end
         end
         S_PR: begin
            mac_req.a = MAC_A_W'(pa_ff);
            mac_req.b = PROB_SCALE;
            state_in  = S_DEC;
         end
         S_DEC: begin
            if (draw_scaled <= prod) begin
               acc_in   = 1'b0;
               cause_in = CAUSE_RANDOM;
               count_in = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register, parts the sequencer from the rsp side
   always_comb begin
      rsp_acc_in   = rsp_acc_ff;
      rsp_cause_in = rsp_cause_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_acc_in   = acc_ff;
         rsp_cause_in = cause_ff;
         rsp_avg_in   = avg_ff[AVG_W-1:THR_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff         <= 1'b0;
         weight_ff     <= Q16_W'(131);
         min_thr_ff    <= THR_W'(1280);
         max_thr_ff    <= THR_W'(3840);
         max_prob_ff   <= Q16_W'(6554);
         cnt_lim_ff    <= Q16_W'(10);
         avg_ff        <= '0;
         count_ff      <= COUNT_RESET;
         idle_start_ff <= '0;
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         en_ff         <= en_in;
         weight_ff     <= weight_in;
         min_thr_ff    <= min_thr_in;
         max_thr_ff    <= max_thr_in;
         max_prob_ff   <= max_prob_in;
         cnt_lim_ff    <= cnt_lim_in;
         avg_ff        <= avg_in;
         count_ff      <= count_in;
         idle_start_ff <= idle_start_in;
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      q_ff         <= q_in;
      draw_ff      <= draw_in;
      m_ff         <= m_in;
      res_ff       <= res_in;
      base_ff      <= base_in;
      pb_ff        <= pb_in;
      pa_ff        <= pa_in;
      acc_ff       <= acc_in;
      cause_ff     <= cause_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_cause_ff <= rsp_cause_in;
      rsp_avg_ff   <= rsp_avg_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accept     = rsp_acc_ff;
   assign rsp_drop_cause = rsp_cause_ff;
   assign rsp_avg_len_q8 = rsp_avg_ff;

   // accept and cause always agree on a decision beat
   a_accept_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accept == (rsp_drop_cause == CAUSE_NONE)))
      else $error("accept flag and drop cause disagree");

   // an accepted arrival occupies the sequencer
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("sequencer idle after taking an arrival");

   // count only goes negative as minus one
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff[COUNT_W-1] |-> count_ff == COUNT_RESET)
      else $error("since-drop count out of range");

   // average never exceeds the largest queue length
   a_avg_bound: assert property (@(posedge clock) disable iff (reset)
      avg_ff <= AVG_MAX)
      else $error("average above queue length limit");

endmodule
`default_nettype wire

// ===== dv/tb_red_queue_drop_decision_top.sv =====
// testbench for the red drop decision block: random and directed arrivals against a predictor
`default_nettype none
module tb_red_queue_drop_decision_top;
   import rqd_pkg::*;

   // run bounds: worst decision path per arrival plus the longest gaps on both sides
   localparam int RUN_LIMIT       = 1000000;
   localparam int DRAIN_CYCLES    = 150;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int LONG_HOLD       = 400;

   typedef struct {
      logic [QLEN_W-1:0] qlen;
      logic [TIME_W-1:0] tick;
      logic [DRAW_W-1:0] draw;
   } arrival_type;

   typedef struct {
      logic              accept;
      logic [1:0]        cause;
      logic [AVG8_W-1:0] avg_q8;
   } decision_type;

   typedef struct {
      logic             enable;
      logic [Q16_W-1:0] weight;
      logic [THR_W-1:0] min_thr;
      logic [THR_W-1:0] max_thr;
      logic [Q16_W-1:0] max_prob;
      logic [Q16_W-1:0] cnt_lim;
   } red_settings_type;

   // dut inputs, all driven to known values from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [QLEN_W-1:0]    req_queue_len = '0;
   logic [TIME_W-1:0]    req_now_time = '0;
   logic [DRAW_W-1:0]    req_random_draw = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_accept;
   logic [1:0]           rsp_drop_cause;
   logic [AVG8_W-1:0]    rsp_avg_len_q8;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // shadow of the csr registers, reset values
   red_settings_type red_cfg = '{1'b0, 16'd131, 18'd1280, 18'd3840, 16'd6554, 16'd10};

   // predictor state: average in Q10.16, packets since last drop, time of last arrival
   logic [63:0]  red_avg_q16 = '0;
   int           since_drop = -1;
   logic [31:0]  last_arrival_tick = '0;

   arrival_type  arrivals_waiting[$];
   decision_type decisions_due[$];
   logic [31:0]  arrival_tick = '0;

   // handshake bookkeeping shared between driver and monitor
   logic         arrival_taken = 1'b0;
   logic         sender_steady = 1'b0;
   logic         receiver_steady = 1'b0;
   logic         hold_done = 1'b0;
   int           send_gap = 0;
   int           recv_gap = 0;
   int           hold_left = 0;

   int           cycle_count = 0;
   int           mismatch_count = 0;
   int           decisions_checked = 0;
   int           settings_used = 0;
   int           accepted_tally = 0;
   int           cause_tally[4] = '{0, 0, 0, 0};

   red_queue_drop_decision_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_queue_len   (req_queue_len),
      .req_now_time    (req_now_time),
      .req_random_draw (req_random_draw),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accept      (rsp_accept),
      .rsp_drop_cause  (rsp_drop_cause),
      .rsp_avg_len_q8  (rsp_avg_len_q8),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) cycle_count++;

   // Q1.16 multiply with round half up
   function automatic logic [63:0] round_q16(input logic [63:0] a, input logic [63:0] b);
      return (a * b + 64'd32768) >> 16;
   endfunction

   // red decision for one arrival; advances the predictor state
   function automatic decision_type decide_arrival(input arrival_type a);
      decision_type d;
      logic [63:0]  keep, qv, draw, lo_f, hi_f, pw, base, pb, cp, pa, avg8;
      logic [31:0]  idle_ticks;
      keep = 64'd65536 - 64'(red_cfg.weight);
      lo_f = 64'(red_cfg.min_thr) << THR_SHIFT;
      hi_f = 64'(red_cfg.max_thr) << THR_SHIFT;
      qv   = (a.qlen > MAX_QUEUE_LEN) ? 64'(MAX_QUEUE_LEN) : 64'(a.qlen);
      draw = (a.draw > DRAW_MAX) ? 64'(DRAW_MAX) : 64'(a.draw);
      if (qv == 0) begin
         // empty queue: decay by (1-w)^idle via square-and-multiply
         idle_ticks = a.tick - last_arrival_tick;
         pw = 64'd65536;
         base = keep;
         for (int i = 0; i < TIME_W; i++) begin
            if (idle_ticks[i]) pw = round_q16(pw, base);
            base = round_q16(base, base);
         end
         red_avg_q16 = round_q16(red_avg_q16, pw);
      end else begin
         red_avg_q16 = (keep * red_avg_q16 + 64'(red_cfg.weight) * (qv << FRAC_BITS)
                        + 64'd32768) >> 16;
      end
      last_arrival_tick = a.tick;
      d.accept = 1'b1;
      d.cause  = CAUSE_NONE;
      if (red_cfg.enable) begin
         if (red_avg_q16 < lo_f) begin
            since_drop = -1;
         end else if (red_avg_q16 > hi_f) begin
            d.accept = 1'b0;
            d.cause  = CAUSE_ABOVE;
            since_drop = 0;
         end else begin
            if (since_drop < 65535) since_drop++;
            // empty band when thresholds are equal: full max probability
            pb = (hi_f > lo_f) ? (64'(red_cfg.max_prob) * (red_avg_q16 - lo_f)) / (hi_f - lo_f)
                               : 64'(red_cfg.max_prob);
            cp = 64'(since_drop) * pb;
            if (cp >= 64'd65536) begin
               pa = 64'd65536;
            end else begin
               pa = (pb << 16) / (64'd65536 - cp);
               if (pa > 64'd65536) pa = 64'd65536;
            end
            if (since_drop >= int'(red_cfg.cnt_lim)) begin
               d.accept = 1'b0;
               d.cause  = CAUSE_LIMIT;
               since_drop = 0;
            end else if (draw * 64'd65536 <= pa * 64'd100) begin
               d.accept = 1'b0;
               d.cause  = CAUSE_RANDOM;
               since_drop = 0;
            end
         end
      end
      avg8 = red_avg_q16 >> THR_SHIFT;
      d.avg_q8 = (avg8 > 64'h3FFFF) ? '1 : avg8[AVG8_W-1:0];
      return d;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // queue length hovering around the middle of the threshold band
   function automatic logic [QLEN_W-1:0] pick_qlen(input red_settings_type s);
      int lo_pk, hi_pk, center, spread, r, q;
      lo_pk  = int'(s.min_thr) / 256;
      hi_pk  = int'(s.max_thr) / 256;
      center = (lo_pk + hi_pk) / 2;
      spread = ((hi_pk > lo_pk) ? hi_pk - lo_pk : lo_pk - hi_pk) / 2 + 3;
      r = $urandom_range(0, 99);
      if (r < 8) q = 0;
      else if (r < 11) q = $urandom_range(0, MAX_QUEUE_LEN);
      else if (r < 13) q = MAX_QUEUE_LEN;
      else q = center - spread + int'($urandom_range(0, 2 * spread));
      if (q < 0) q = 0;
      if (q > MAX_QUEUE_LEN) q = MAX_QUEUE_LEN;
      return QLEN_W'(q);
   endfunction

   // small time steps, some medium idles, rare jumps anywhere (wrap included)
   function automatic logic [TIME_W-1:0] pick_tick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) arrival_tick += $urandom_range(0, 6);
      else if (r < 97) arrival_tick += $urandom_range(7, 3000);
      else arrival_tick = $urandom();
      return arrival_tick;
   endfunction

   // draws beyond 99 count as 99 in the block
   function automatic logic [DRAW_W-1:0] pick_draw();
      if ($urandom_range(0, 99) < 88) return DRAW_W'($urandom_range(0, 99));
      return DRAW_W'($urandom_range(0, 127));
   endfunction

   function automatic red_settings_type random_settings();
      red_settings_type s;
      s.enable   = ($urandom_range(0, 9) != 0);
      s.weight   = Q16_W'($urandom_range(1024, 65535));
      s.min_thr  = THR_W'($urandom_range(0, 20 * 256));
      s.max_thr  = s.min_thr + THR_W'($urandom_range(0, 30 * 256));
      s.max_prob = Q16_W'($urandom_range(1, 65535));
      s.cnt_lim  = Q16_W'($urandom_range(1, 40));
      return s;
   endfunction

   task automatic add_arrival(input int q, input logic [TIME_W-1:0] t, input int d);
      arrival_type a;
      a.qlen = QLEN_W'(q);
      a.tick = t;
      a.draw = DRAW_W'(d);
      arrivals_waiting.push_back(a);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // all six registers each time, block idle
   task automatic apply_settings(input red_settings_type s);
      write_csr(REG_ENABLE,   CSR_DAT_W'(s.enable));
      write_csr(REG_WEIGHT,   CSR_DAT_W'(s.weight));
      write_csr(REG_MIN_THR,  CSR_DAT_W'(s.min_thr));
      write_csr(REG_MAX_THR,  CSR_DAT_W'(s.max_thr));
      write_csr(REG_MAX_PROB, CSR_DAT_W'(s.max_prob));
      write_csr(REG_CNT_LIM,  CSR_DAT_W'(s.cnt_lim));
      red_cfg = s;
      settings_used++;
   endtask

   // every queued arrival offered, accepted and answered
   task automatic wait_quiet();
      while (arrivals_waiting.size() != 0 || req_valid || decisions_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
   endtask

   // arrival driver: new beat only once the previous one was taken, then maybe a gap
   always @(negedge clock) begin
      arrival_type nxt;
      if ($urandom_range(0, 199) == 0) sender_steady = !sender_steady;
      if (!reset && (!req_valid || arrival_taken)) begin
         arrival_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (arrivals_waiting.size() != 0) begin
            nxt = arrivals_waiting.pop_front();
            req_valid       <= 1'b1;
            req_queue_len   <= nxt.qlen;
            req_now_time    <= nxt.tick;
            req_random_draw <= nxt.draw;
            send_gap = sender_steady ? 0 : idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // decision receiver: random stalls, steady stretches, one long hold-off to back up the block
   always @(negedge clock) begin
      if ($urandom_range(0, 299) == 0) receiver_steady = !receiver_steady;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && decisions_checked >= 60) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!receiver_steady && $urandom_range(0, 3) == 0) recv_gap = idle_len();
      end
   end

   // monitor: check decision beats in order, predict each accepted arrival
   always @(posedge clock) begin
      decision_type due;
      arrival_type  got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (decisions_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: decision beat with none outstanding, accept %0d cause %0d avg %0d",
                        $time, rsp_accept, rsp_drop_cause, rsp_avg_len_q8);
            end else begin
               due = decisions_due.pop_front();
               decisions_checked++;
               if (due.accept) accepted_tally++;
               cause_tally[due.cause]++;
               if (rsp_accept !== due.accept) report_field("accept", due.accept, rsp_accept);
               if (rsp_drop_cause !== due.cause)
                  report_field("drop_cause", due.cause, rsp_drop_cause);
               if (rsp_avg_len_q8 !== due.avg_q8)
                  report_field("avg_len_q8", due.avg_q8, rsp_avg_len_q8);
            end
         end
         if (req_valid && req_ready) begin
            got.qlen = req_queue_len;
            got.tick = req_now_time;
            got.draw = req_random_draw;
            decisions_due.push_back(decide_arrival(got));
            arrival_taken = 1'b1;
         end
      end
   end

   // watchdog on the cycle counter
   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("run stopped at cycle limit %0d, %0d decisions outstanding",
               RUN_LIMIT, decisions_due.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      red_settings_type plan[$];
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings, red off: extremes of length, huge idle, time wrap, big draws
      add_arrival(MAX_QUEUE_LEN, 32'd5, 0);
      add_arrival(0, 32'hFFFF_FFF0, 127);
      add_arrival(512, 32'hFFFF_FFFA, 99);
      add_arrival(0, 32'h0000_0003, 64);
      wait_quiet();

      // heavy weight, full max probability, low count limit: above max, decay, band, below min
      apply_settings('{1'b1, 16'd32768, 18'd1280, 18'd3840, 16'd65535, 16'd4});
      add_arrival(MAX_QUEUE_LEN, 32'd100, 99);
      add_arrival(MAX_QUEUE_LEN, 32'd101, 127);
      add_arrival(0, 32'd102, 99);
      add_arrival(0, 32'd104, 99);
      add_arrival(10, 32'd105, 99);
      add_arrival(10, 32'd106, 127);
      add_arrival(10, 32'd107, 99);
      add_arrival(10, 32'd108, 99);
      add_arrival(10, 32'd109, 0);
      add_arrival(10, 32'd110, 99);
      add_arrival(10, 32'd111, 127);
      add_arrival(10, 32'd112, 99);
      add_arrival(1, 32'd120, 0);
      wait_quiet();

      // equal thresholds: weight near one pins the average exactly on both
      apply_settings('{1'b1, 16'd65535, 18'd2048, 18'd2048, 16'd30000, 16'd65535});
      add_arrival(8, 32'd200, 99);
      add_arrival(8, 32'd201, 99);
      add_arrival(8, 32'd202, 99);
      add_arrival(8, 32'd203, 0);
      add_arrival(0, 32'd203, 99);
      wait_quiet();

      // random part: fixed corner settings first, then random ones
      plan.push_back('{1'b1, 16'd8192,  18'd1280,   18'd3840,   16'd6554,  16'd10});
      plan.push_back('{1'b1, 16'd32768, 18'd512,    18'd5120,   16'd65535, 16'd65535});
      plan.push_back('{1'b1, 16'd1,     18'd0,      18'd262143, 16'd1,     16'd1});
      plan.push_back('{1'b1, 16'd65535, 18'd262143, 18'd262143, 16'd65535, 16'd2});
      plan.push_back('{1'b0, 16'd0,     18'd0,      18'd0,      16'd0,     16'd0});
      plan.push_back('{1'b1, 16'd0,     18'd0,      18'd0,      16'd65535, 16'd0});
      plan.push_back('{1'b1, 16'd16384, 18'd3840,   18'd1280,   16'd30000, 16'd20});
      plan.push_back('{1'b1, 16'd4096,  18'd2560,   18'd2560,   16'd40000, 16'd65535});
      repeat (6) plan.push_back(random_settings());

      foreach (plan[p]) begin
         apply_settings(plan[p]);
         repeat (ITEMS_PER_PHASE) add_arrival(pick_qlen(plan[p]), pick_tick(), pick_draw());
         wait_quiet();
      end

      // let any stray beat show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d decisions under %0d register settings in %0d cycles",
               decisions_checked, settings_used, cycle_count);
      $display("accepted %0d, over max %0d, random drops %0d, count limit drops %0d",
               accepted_tally, cause_tally[CAUSE_ABOVE], cause_tally[CAUSE_RANDOM],
               cause_tally[CAUSE_LIMIT]);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
